// File: rtl/boh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit density histogram package
// Shared widths, codes, defaults and transfer types of the histogram core.
// ----------------------------------------------------------------------------
package boh_pkg;

   // Default sizes.
   localparam int DEF_IMAGE_WIDTH  = 512;
   localparam int DEF_IMAGE_HEIGHT = 256;
   localparam int DEF_MAX_ORBIT    = 512;
   localparam int DEF_FRAC_BITS    = 28;

   // Fixed field widths.
   localparam int Z_W     = 36;
   localparam int C_W     = 31;
   localparam int ROW_IN_W = 8;
   localparam int COL_IN_W = 9;
   localparam int ITER_W  = 10;
   localparam int LIMIT_W = 33;
   localparam int BIN_W   = 9;

   localparam logic [BIN_W-1:0] BIN_MAX = 9'd256;

   // Item kinds.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Register indexes.
   localparam logic CSR_MAX_ITER  = 1'b0;
   localparam logic CSR_ESC_LIMIT = 1'b1;

   // One queued input transaction, classified by the front end.
   typedef struct packed {
      logic                       kind;
      logic signed [C_W-1:0]      c_real;
      logic signed [C_W-1:0]      c_imag;
      logic [ROW_IN_W-1:0]        read_row;
      logic [COL_IN_W-1:0]        read_col;
      logic                       in_range;
   } boh_item_type;

   // Control from the back end to the front end.
   typedef struct packed {
      logic take;
      logic clearing;
   } boh_ctl_type;

endpackage

// File: rtl/boh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module boh_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/boh_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram core front end
// Accepts input transactions, classifies reads, and queues them in two slots.
// ----------------------------------------------------------------------------
module boh_front import boh_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_kind,
   input  logic signed [C_W-1:0]      req_c_real,
   input  logic signed [C_W-1:0]      req_c_imag,
   input  logic [ROW_IN_W-1:0]        req_read_row,
   input  logic [COL_IN_W-1:0]        req_read_col,
   input  boh_ctl_type                ctl,
   output logic                       q_valid,
   output boh_item_type               q_item
);

   boh_item_type item_ff [2];
   boh_item_type item_in;
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push_ok;

   // Classify: a read is in range when both coordinates fall inside the image.
   always_comb begin
      item_in.kind     = req_kind;
      item_in.c_real   = req_c_real;
      item_in.c_imag   = req_c_imag;
      item_in.read_row = req_read_row;
      item_in.read_col = req_read_col;
      item_in.in_range = (32'(req_read_row) < IMAGE_HEIGHT) &&
                         (32'(req_read_col) < IMAGE_WIDTH);
   end

   assign req_full = (cnt_ff == 2'd2) || ctl.clearing;
   assign push_ok  = req_push && !req_full;
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = item_ff[rptr_ff];

   // Pointer and count update.
   always_comb begin
      wptr_in = push_ok ? !wptr_ff : wptr_ff;
      rptr_in = ctl.take ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff;
      if (push_ok && !ctl.take) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push_ok && ctl.take) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Queue slots.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         item_ff[wptr_ff] <= item_in;
      end
   end

endmodule

// File: rtl/boh_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Histogram core back end
// Iterates the orbit, accumulates it into the histogram, serves bin reads.
// ----------------------------------------------------------------------------
module boh_back import boh_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
   parameter int MAX_ORBIT    = DEF_MAX_ORBIT,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  boh_item_type         q_item,
   output boh_ctl_type          ctl,
   input  logic [ITER_W-1:0]    max_iter,
   input  logic [LIMIT_W-1:0]   esc_limit,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic                 rsp_escaped,
   output logic [ITER_W-1:0]    rsp_orbit_length,
   output logic [BIN_W-1:0]     rsp_bin_value
);

   localparam int BINS    = IMAGE_WIDTH * IMAGE_HEIGHT;
   localparam int BA_W    = $clog2(BINS);
   localparam int OA_W    = (MAX_ORBIT > 1) ? $clog2(MAX_ORBIT) : 1;
   localparam int N_W     = $clog2(MAX_ORBIT + 1);
   localparam int CMP_W   = (N_W > ITER_W) ? N_W : ITER_W;
   localparam int HALF_W  = Z_W / 2;
   localparam int PP_W    = Z_W + HALF_W;
   localparam int FULL_W  = 2 * Z_W;
   localparam int PRD_W   = FULL_W + 1;
   localparam int SUM_W   = PRD_W + 2;
   localparam int EXT_W   = (FRAC_BITS + 4 > Z_W + 1) ? FRAC_BITS + 4 : Z_W + 1;
   localparam int OFF_W   = FRAC_BITS + 3;
   localparam int HB_W    = $clog2(IMAGE_HEIGHT + 1);
   localparam int WB_W    = $clog2(IMAGE_WIDTH + 1);
   localparam int RP_W    = OFF_W + HB_W;
   localparam int CP_W    = OFF_W + WB_W;
   localparam int SH      = FRAC_BITS + 2;

   localparam logic signed [EXT_W-1:0] TWO = EXT_W'(64'd2 << FRAC_BITS);
   localparam logic signed [SUM_W-1:0] ZMAX = SUM_W'((64'd1 << (Z_W - 1)) - 64'd1);
   localparam logic signed [SUM_W-1:0] ZMIN = -ZMAX - SUM_W'(1);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_RD_REQ   = 4'd2;
   localparam logic [3:0] S_RD_DATA  = 4'd3;
   localparam logic [3:0] S_TOP      = 4'd4;
   localparam logic [3:0] S_MUL      = 4'd5;
   localparam logic [3:0] S_EVAL     = 4'd6;
   localparam logic [3:0] S_ACC_RD   = 4'd7;
   localparam logic [3:0] S_ACC_MAP  = 4'd8;
   localparam logic [3:0] S_ACC_ADDR = 4'd9;
   localparam logic [3:0] S_ACC_BIN  = 4'd10;
   localparam logic [3:0] S_ACC_UPD  = 4'd11;
   localparam logic [3:0] S_DONE     = 4'd12;

   function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
      logic signed [Z_W-1:0] r;
      if (v > ZMAX) begin
         r = ZMAX[Z_W-1:0];
      end else if (v < ZMIN) begin
         r = ZMIN[Z_W-1:0];
      end else begin
         r = v[Z_W-1:0];
      end
      return r;
   endfunction

   logic [3:0]              state_ff, state_in;
   logic [BA_W-1:0]         clr_ff, clr_in;
   logic [BA_W-1:0]         baddr_ff, baddr_in;
   logic signed [Z_W-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [Z_W-1:0]   cr_ff, cr_in, ci_ff, ci_in;
   logic [N_W-1:0]          n_ff, n_in, lim_ff, lim_in, j_ff, j_in;
   logic [2:0]              mstep_ff, mstep_in;
   logic [PP_W-1:0]         pp_ff, pp_in, lo_ff, lo_in;
   logic signed [PRD_W-1:0] x2_ff, x2_in, y2_ff, y2_in, xy_ff, xy_in;
   logic                    esc_ff, esc_in, ok_ff, ok_in;
   logic [RP_W-1:0]         rprod_ff, rprod_in;
   logic [CP_W-1:0]         cprod_ff, cprod_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_esc_ff, out_esc_in;
   logic [ITER_W-1:0]       out_len_ff, out_len_in;
   logic [BIN_W-1:0]        out_bin_ff, out_bin_in;
   logic [BIN_W-1:0]        res_bin_ff, res_bin_in;

   // Memory ports.
   logic                    bin_wr_en, bin_rd_en;
   logic [BA_W-1:0]         bin_wr_addr;
   logic [BIN_W-1:0]        bin_wr_data, bin_rd_data;
   logic                    orb_wr_en, orb_rd_en;
   logic signed [Z_W-1:0]   orb_wr_re, orb_wr_im;
   logic [Z_W-1:0]          orb_rd_re, orb_rd_im;

   // Multiplier datapath signals.
   logic [1:0]              issue_pair, use_pair;
   logic signed [Z_W-1:0]   op_a, op_b;
   logic [Z_W-1:0]          mag_a, mag_b;
   logic [HALF_W-1:0]       half_b;
   logic                    use_neg;
   logic [FULL_W-1:0]       full_mag;
   logic signed [PRD_W-1:0] prod_s, prod_sh;

   // Evaluation and mapping signals.
   logic [SUM_W-1:0]        mag2;
   logic signed [SUM_W-1:0] nx_sum, ny_sum;
   logic signed [Z_W-1:0]   nx, ny;
   logic signed [EXT_W-1:0] re_x, im_x;
   logic                    pt_in;
   logic [OFF_W-1:0]        off_r, off_c;
   logic [HB_W:0]           row_v;
   logic [WB_W:0]           col_v;
   logic [CMP_W-1:0]        max_ext;

   // Operand selection for the issuing step and sign of the consumed product.
   always_comb begin
      issue_pair = mstep_ff[2:1];
      use_pair   = 2'((mstep_ff - 3'd1) >> 1);
      op_a = (issue_pair == 2'd1) ? y_ff : x_ff;
      op_b = (issue_pair == 2'd0) ? x_ff : y_ff;
      mag_a = op_a[Z_W-1] ? Z_W'(-op_a) : Z_W'(op_a);
      mag_b = op_b[Z_W-1] ? Z_W'(-op_b) : Z_W'(op_b);
      half_b = mstep_ff[0] ? mag_b[Z_W-1:HALF_W] : mag_b[HALF_W-1:0];
      pp_in = PP_W'(mag_a * half_b);
      case (use_pair)
         2'd0:    use_neg = 1'b0;
         2'd1:    use_neg = 1'b0;
         default: use_neg = x_ff[Z_W-1] ^ y_ff[Z_W-1];
      endcase
      full_mag = FULL_W'(lo_ff) + (FULL_W'(pp_ff) << HALF_W);
      prod_s   = use_neg ? -$signed({1'b0, full_mag}) : $signed({1'b0, full_mag});
      prod_sh  = prod_s >>> FRAC_BITS;
   end

   // Escape test and next orbit point.
   always_comb begin
      mag2   = SUM_W'(x2_ff) + SUM_W'(y2_ff);
      nx_sum = SUM_W'(x2_ff) - SUM_W'(y2_ff) + SUM_W'(cr_ff);
      ny_sum = (SUM_W'(xy_ff) <<< 1) + SUM_W'(ci_ff);
      nx     = sat_z(nx_sum);
      ny     = sat_z(ny_sum);
   end

   // Mapping of a stored orbit point onto the image grid.
   always_comb begin
      re_x  = EXT_W'($signed(orb_rd_re));
      im_x  = EXT_W'($signed(orb_rd_im));
      pt_in = (re_x >= -TWO) && (re_x <= TWO) && (im_x >= -TWO) && (im_x <= TWO);
      off_r = OFF_W'(re_x + TWO);
      off_c = OFF_W'(im_x + TWO);
      rprod_in = RP_W'(off_r * RP_W'(IMAGE_HEIGHT));
      cprod_in = CP_W'(off_c * CP_W'(IMAGE_WIDTH));
      row_v = (HB_W + 1)'(rprod_ff >> SH);
      col_v = (WB_W + 1)'(cprod_ff >> SH);
   end

   assign max_ext = CMP_W'(max_iter);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      baddr_in     = baddr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      n_in         = n_ff;
      lim_in       = lim_ff;
      j_in         = j_ff;
      mstep_in     = mstep_ff;
      lo_in        = lo_ff;
      x2_in        = x2_ff;
      y2_in        = y2_ff;
      xy_in        = xy_ff;
      esc_in       = esc_ff;
      ok_in        = ok_ff;
      res_bin_in   = res_bin_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_esc_in   = out_esc_ff;
      out_len_in   = out_len_ff;
      out_bin_in   = out_bin_ff;
      ctl.take     = 1'b0;
      ctl.clearing = 1'b0;
      bin_wr_en    = 1'b0;
      bin_wr_addr  = baddr_ff;
      bin_wr_data  = '0;
      bin_rd_en    = 1'b0;
      orb_wr_en    = 1'b0;
      orb_rd_en    = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            // Sweep the histogram to zero, one bin a cycle.
            ctl.clearing = 1'b1;
            bin_wr_en    = 1'b1;
            bin_wr_addr  = clr_ff;
            clr_in       = clr_ff + BA_W'(1);
            if (32'(clr_ff) == BINS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               ctl.take   = 1'b1;
               esc_in     = 1'b0;
               n_in       = '0;
               res_bin_in = '0;
               if (q_item.kind == KIND_READ) begin
                  baddr_in = BA_W'(BA_W'(q_item.read_row) * BA_W'(IMAGE_WIDTH)) +
                             BA_W'(q_item.read_col);
                  state_in = q_item.in_range ? S_RD_REQ : S_DONE;
               end else begin
                  x_in     = '0;
                  y_in     = '0;
                  cr_in    = Z_W'(q_item.c_real);
                  ci_in    = Z_W'(q_item.c_imag);
                  lim_in   = (max_ext < CMP_W'(MAX_ORBIT)) ? N_W'(max_ext) : N_W'(MAX_ORBIT);
                  state_in = S_TOP;
               end
            end
         end
         S_RD_REQ: begin
            bin_rd_en = 1'b1;
            state_in  = S_RD_DATA;
         end
         S_RD_DATA: begin
            res_bin_in = bin_rd_data;
            state_in   = S_DONE;
         end
         S_TOP: begin
            // Limit reached means the orbit is bounded.
            if (n_ff >= lim_ff) begin
               esc_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               mstep_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // Two half products per square or cross term, each used in the cycle after its issue.
            mstep_in = mstep_ff + 3'd1;
            if (mstep_ff != 3'd0) begin
               if (mstep_in[0]) begin
                  case (use_pair)
                     2'd0:    x2_in = prod_sh;
                     2'd1:    y2_in = prod_sh;
                     default: xy_in = prod_sh;
                  endcase
               end else begin
                  lo_in = pp_ff;
               end
            end
            if (mstep_ff == 3'd6) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (mag2 > SUM_W'(esc_limit)) begin
               esc_in = 1'b1;
               j_in   = '0;
               state_in = (n_ff != '0) ? S_ACC_RD : S_DONE;
            end else begin
               orb_wr_en = 1'b1;
               x_in      = nx;
               y_in      = ny;
               n_in      = n_ff + N_W'(1);
               state_in  = S_TOP;
            end
         end
         S_ACC_RD: begin
            orb_rd_en = 1'b1;
            state_in  = S_ACC_MAP;
         end
         S_ACC_MAP: begin
            ok_in    = pt_in;
            state_in = S_ACC_ADDR;
         end
         S_ACC_ADDR: begin
            ok_in    = ok_ff && (32'(row_v) < IMAGE_HEIGHT) && (32'(col_v) < IMAGE_WIDTH);
            baddr_in = BA_W'(BA_W'(row_v) * BA_W'(IMAGE_WIDTH)) + BA_W'(col_v);
            state_in = S_ACC_BIN;
         end
         S_ACC_BIN: begin
            if (ok_ff) begin
               bin_rd_en = 1'b1;
               state_in  = S_ACC_UPD;
            end else begin
               j_in     = j_ff + N_W'(1);
               state_in = (j_in == n_ff) ? S_DONE : S_ACC_RD;
            end
         end
         S_ACC_UPD: begin
            // Saturating increment of the bin.
            bin_wr_en   = 1'b1;
            bin_wr_data = (bin_rd_data < BIN_MAX) ? bin_rd_data + BIN_W'(1) : bin_rd_data;
            j_in        = j_ff + N_W'(1);
            state_in    = (j_in == n_ff) ? S_DONE : S_ACC_RD;
         end
         S_DONE: begin
            if (!out_valid_in) begin
               out_valid_in = 1'b1;
               out_esc_in   = esc_ff;
               out_len_in   = ITER_W'(n_ff);
               out_bin_in   = res_bin_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign orb_wr_re = nx;
   assign orb_wr_im = ny;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      baddr_ff   <= baddr_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      n_ff       <= n_in;
      lim_ff     <= lim_in;
      j_ff       <= j_in;
      mstep_ff   <= mstep_in;
      pp_ff      <= pp_in;
      lo_ff      <= lo_in;
      x2_ff      <= x2_in;
      y2_ff      <= y2_in;
      xy_ff      <= xy_in;
      esc_ff     <= esc_in;
      ok_ff      <= ok_in;
      rprod_ff   <= rprod_in;
      cprod_ff   <= cprod_in;
      res_bin_ff <= res_bin_in;
      out_esc_ff <= out_esc_in;
      out_len_ff <= out_len_in;
      out_bin_ff <= out_bin_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_escaped      = out_esc_ff;
   assign rsp_orbit_length = out_len_ff;
   assign rsp_bin_value    = out_bin_ff;

   // Histogram memory.
   boh_ram #(
      .WIDTH  (BIN_W),
      .DEPTH  (BINS),
      .ADDR_W (BA_W)
   ) u_bins (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (bin_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (baddr_ff),
      .rd_data (bin_rd_data)
   );

   // Orbit stores, real and imaginary parts.
   boh_ram #(
      .WIDTH  (Z_W),
      .DEPTH  (MAX_ORBIT),
      .ADDR_W (OA_W)
   ) u_orbit_re (
      .clock   (clock),
      .wr_en   (orb_wr_en),
      .wr_addr (n_ff[OA_W-1:0]),
      .wr_data (orb_wr_re),
      .rd_en   (orb_rd_en),
      .rd_addr (j_ff[OA_W-1:0]),
      .rd_data (orb_rd_re)
   );

   boh_ram #(
      .WIDTH  (Z_W),
      .DEPTH  (MAX_ORBIT),
      .ADDR_W (OA_W)
   ) u_orbit_im (
      .clock   (clock),
      .wr_en   (orb_wr_en),
      .wr_addr (n_ff[OA_W-1:0]),
      .wr_data (orb_wr_im),
      .rd_en   (orb_rd_en),
      .rd_addr (j_ff[OA_W-1:0]),
      .rd_data (orb_rd_im)
   );

endmodule

// File: rtl/buddhabrot_orbit_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit density histogram core
// Iterates z = z*z + c per sample and accumulates escaped orbits into bins.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  req       req_push / req_full  kind, c_real, c_imag, read_row, read_col
//  rsp       rsp_pop / rsp_empty  escaped, orbit_length, bin_value
//  csr       csr_we               csr_index, csr_wdata
//
// A sample iterates in the shared split multiplier and then, if it escapes,
// walks its stored points in the histogram update pass.
// Transactions are worked one at a time.
// After reset the histogram is swept to zero, with req_full high.
// A two-entry queue takes requests while a result waits.
// ----------------------------------------------------------------------------
module buddhabrot_orbit_histogram_core import boh_pkg::*; #(
   parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
   parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
   parameter int MAX_ORBIT    = DEF_MAX_ORBIT,
   parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic                  req_kind,
   input  logic signed [C_W-1:0] req_c_real,
   input  logic signed [C_W-1:0] req_c_imag,
   input  logic [ROW_IN_W-1:0]   req_read_row,
   input  logic [COL_IN_W-1:0]   req_read_col,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_escaped,
   output logic [ITER_W-1:0]     rsp_orbit_length,
   output logic [BIN_W-1:0]      rsp_bin_value,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [LIMIT_W-1:0]    csr_wdata
);

   localparam logic [63:0] TWO_FIX   = 64'd2 << FRAC_BITS;
   localparam logic [63:0] LIMIT_MAX = (64'd1 << LIMIT_W) - 64'd1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET =
      (TWO_FIX > LIMIT_MAX) ? LIMIT_MAX[LIMIT_W-1:0] : TWO_FIX[LIMIT_W-1:0];
   localparam logic [ITER_W-1:0] ITER_RESET = 10'd512;

   logic [ITER_W-1:0]  max_iter_ff, max_iter_in;
   logic [LIMIT_W-1:0] esc_limit_ff, esc_limit_in;
   logic               q_valid;
   boh_item_type       q_item;
   boh_ctl_type        ctl;

   // Configuration register writes.
   always_comb begin
      max_iter_in  = max_iter_ff;
      esc_limit_in = esc_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_ITER:  max_iter_in  = csr_wdata[ITER_W-1:0];
            CSR_ESC_LIMIT: esc_limit_in = csr_wdata;
            default:       max_iter_in  = max_iter_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= ITER_RESET;
         esc_limit_ff <= LIMIT_RESET;
      end else begin
         max_iter_ff  <= max_iter_in;
         esc_limit_ff <= esc_limit_in;
      end
   end

   // Front end: accept and classify.
   boh_front #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_kind     (req_kind),
      .req_c_real   (req_c_real),
      .req_c_imag   (req_c_imag),
      .req_read_row (req_read_row),
      .req_read_col (req_read_col),
      .ctl          (ctl),
      .q_valid      (q_valid),
      .q_item       (q_item)
   );

   // Back end: iterate, accumulate, respond.
   boh_back #(
      .IMAGE_WIDTH  (IMAGE_WIDTH),
      .IMAGE_HEIGHT (IMAGE_HEIGHT),
      .MAX_ORBIT    (MAX_ORBIT),
      .FRAC_BITS    (FRAC_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .ctl              (ctl),
      .max_iter         (max_iter_ff),
      .esc_limit        (esc_limit_ff),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_escaped      (rsp_escaped),
      .rsp_orbit_length (rsp_orbit_length),
      .rsp_bin_value    (rsp_bin_value)
   );

endmodule

// File: tb/tb_buddhabrot_orbit_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit density histogram core testbench
// Drives sample and bin-read transactions through the request queue, predicts
// every orbit and histogram update in a scoreboard, and compares each popped
// response field by field. Both queue sides idle at random, and the run
// steps through several iteration-limit and escape-bound settings.
// ----------------------------------------------------------------------------
module tb_buddhabrot_orbit_histogram_core;
   import boh_pkg::*;

   localparam int  IMG_W      = DEF_IMAGE_WIDTH;
   localparam int  IMG_H      = DEF_IMAGE_HEIGHT;
   localparam int  ORBIT_MAX  = DEF_MAX_ORBIT;
   localparam int  FRAC       = DEF_FRAC_BITS;
   localparam int  ONE        = 1 << FRAC;
   localparam int  TWO        = 2 << FRAC;
   localparam int  CYCLE_CAP  = 20_000_000;
   localparam int  HOLD_LEN   = 2000;

   // One expected response.
   typedef struct {
      bit           escaped;
      bit [9:0]     orbit_length;
      bit [8:0]     bin_value;
   } orbit_result_type;

   // Scoreboard: its own copy of the registers and the histogram.
   class orbit_density_scoreboard;
      bit [ITER_W-1:0]  iter_limit;
      bit [LIMIT_W-1:0] escape_bound;
      bit [BIN_W-1:0]   density [0:IMG_H*IMG_W-1];
      orbit_result_type results_due [$];
      int               touched_bins [$];
      int               errors;

      function new();
         iter_limit   = 10'd512;
         escape_bound = LIMIT_W'(TWO);
         errors       = 0;
         foreach (density[i]) density[i] = '0;
      endfunction

      function int pending();
         return results_due.size();
      endfunction

      function void set_register(logic idx, bit [LIMIT_W-1:0] value);
         if (idx == CSR_MAX_ITER) iter_limit = value[ITER_W-1:0];
         else escape_bound = value;
      endfunction

      // Fixed point product, floored by the arithmetic shift.
      function longint scaled_product(longint a, longint b);
         logic signed [71:0] wa, wb, p;
         wa = a;
         wb = b;
         p  = wa * wb;
         return longint'(p >>> FRAC);
      endfunction

      function longint clamp_z(longint v);
         longint zmax;
         zmax = (longint'(1) << 35) - 1;
         if (v > zmax) return zmax;
         if (v < -zmax - 1) return -zmax - 1;
         return v;
      endfunction

      // Work out the response of one accepted transaction.
      function void note_request(logic kind, longint c_re, longint c_im,
                                 int row_in, int col_in);
         orbit_result_type r;
         longint x, y, x2, y2, xy, nx, two_l, row, col;
         longint pts_re [$];
         longint pts_im [$];
         int     limit, n, idx;
         r = '{0, 0, 0};
         if (kind == KIND_READ) begin
            if (row_in < IMG_H && col_in < IMG_W)
               r.bin_value = density[row_in*IMG_W + col_in];
         end else begin
            limit = (iter_limit < ORBIT_MAX) ? iter_limit : ORBIT_MAX;
            x = 0;
            y = 0;
            n = 0;
            while (n < limit) begin
               x2 = scaled_product(x, x);
               y2 = scaled_product(y, y);
               if (x2 + y2 > longint'(escape_bound)) break;
               xy = scaled_product(x, y);
               nx = clamp_z(x2 - y2 + c_re);
               y  = clamp_z(2*xy + c_im);
               x  = nx;
               pts_re.push_back(x);
               pts_im.push_back(y);
               n++;
            end
            r.escaped      = (n < limit);
            r.orbit_length = n[9:0];
            // Escaped orbits land in the histogram.
            if (r.escaped) begin
               two_l = TWO;
               foreach (pts_re[j]) begin
                  if (pts_re[j] < -two_l || pts_re[j] > two_l ||
                      pts_im[j] < -two_l || pts_im[j] > two_l) continue;
                  row = ((pts_re[j] + two_l) * IMG_H) >>> (FRAC + 2);
                  col = ((pts_im[j] + two_l) * IMG_W) >>> (FRAC + 2);
                  if (row >= IMG_H || col >= IMG_W) continue;
                  idx = int'(row)*IMG_W + int'(col);
                  if (density[idx] < BIN_MAX) density[idx]++;
                  touched_bins.push_back(idx);
                  if (touched_bins.size() > 32) void'(touched_bins.pop_front());
               end
            end
         end
         results_due.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("ERROR @%0t: %s got %0d expected %0d", $time, what, got, want);
         errors++;
      endtask

      // Compare one popped response with the oldest expectation.
      task check_response(bit escaped, bit [9:0] orbit_length, bit [8:0] bin_value);
         orbit_result_type e;
         if (results_due.size() == 0) begin
            report_mismatch("unexpected response, escaped", escaped, 0);
         end else begin
            e = results_due.pop_front();
            if (escaped !== e.escaped) report_mismatch("escaped", escaped, e.escaped);
            if (orbit_length !== e.orbit_length)
               report_mismatch("orbit_length", orbit_length, e.orbit_length);
            if (bin_value !== e.bin_value)
               report_mismatch("bin_value", bin_value, e.bin_value);
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_push;
   logic                  req_full;
   logic                  req_kind;
   logic signed [C_W-1:0] req_c_real;
   logic signed [C_W-1:0] req_c_imag;
   logic [ROW_IN_W-1:0]   req_read_row;
   logic [COL_IN_W-1:0]   req_read_col;
   logic                  rsp_empty;
   logic                  rsp_pop;
   logic                  rsp_escaped;
   logic [ITER_W-1:0]     rsp_orbit_length;
   logic [BIN_W-1:0]      rsp_bin_value;
   logic                  csr_we;
   logic                  csr_index;
   logic [LIMIT_W-1:0]    csr_wdata;

   orbit_density_scoreboard sb = new();
   bit  hold_request = 0;
   int  cycle_count  = 0;
   int  burst_left   = 0;

   buddhabrot_orbit_histogram_core dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("buddhabrot_orbit_histogram_core: mismatch");
         $finish;
      end
   end

   // Check every response transaction.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty)
         sb.check_response(rsp_escaped, rsp_orbit_length, rsp_bin_value);
   end

   // Receiver: stretches of steady, patchy and sparse popping, plus one long hold.
   initial begin : receiver
      int stretch;
      int mode;
      stretch = 0;
      mode    = 0;
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
            hold_request = 0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(20, 200);
               mode    = $urandom_range(0, 2);
            end
            stretch--;
            case (mode)
               0: rsp_pop = 1'b1;
               1: rsp_pop = $urandom_range(0, 1);
               default: rsp_pop = ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Offer one request at the falling edge and hold it until accepted.
   task offer(logic kind, int c_re, int c_im, int row_in, int col_in);
      req_push     = 1'b1;
      req_kind     = kind;
      req_c_real   = C_W'(c_re);
      req_c_imag   = C_W'(c_im);
      req_read_row = ROW_IN_W'(row_in);
      req_read_col = COL_IN_W'(col_in);
      forever begin
         @(posedge clock);
         if (!req_full) break;
      end
      sb.note_request(kind, longint'(c_re), longint'(c_im),
                      row_in % 256, col_in % 512);
      @(negedge clock);
   endtask

   task pause_sender(int cycles);
      req_push = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Sender waits for every response, then a short settle time.
   task drain();
      req_push = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task write_register(logic idx, bit [LIMIT_W-1:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      sb.set_register(idx, value);
   endtask

   function int random_coord();
      return int'($urandom_range(0, 1 << 30)) - (1 << 29);
   endfunction

   // One random request with bursty spacing; hot samples revisit one bin.
   task random_request(int hot_pct);
      int pick;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
      end
      burst_left--;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         if (sb.touched_bins.size() != 0 && $urandom_range(0, 1)) begin
            int idx;
            idx = sb.touched_bins[$urandom_range(0, sb.touched_bins.size()-1)];
            offer(KIND_READ, random_coord(), random_coord(), idx / IMG_W, idx % IMG_W);
         end else begin
            offer(KIND_READ, random_coord(), random_coord(),
                  $urandom_range(0, 255), $urandom_range(0, 511));
         end
      end else if ($urandom_range(0, 99) < hot_pct) begin
         offer(KIND_SAMPLE, ONE, ONE, $urandom_range(0, 255), $urandom_range(0, 511));
      end else begin
         offer(KIND_SAMPLE, random_coord(), random_coord(),
               $urandom_range(0, 255), $urandom_range(0, 511));
      end
   endtask

   task random_phase(int iters, bit [LIMIT_W-1:0] bound, int count, int hot_pct);
      drain();
      write_register(CSR_MAX_ITER, LIMIT_W'(iters));
      write_register(CSR_ESC_LIMIT, bound);
      repeat (count) random_request(hot_pct);
   endtask

   // Main stimulus.
   initial begin : stimulus
      reset        = 1'b1;
      req_push     = 1'b0;
      req_kind     = KIND_SAMPLE;
      req_c_real   = '0;
      req_c_imag   = '0;
      req_read_row = '0;
      req_read_col = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_MAX_ITER;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items at the reset settings.
      offer(KIND_SAMPLE, 0, 0, 0, 0);                   // bounded orbit, runs to the limit
      offer(KIND_SAMPLE, -TWO, 0, 255, 511);            // lands on the lowest row
      offer(KIND_SAMPLE, TWO, 0, 0, 0);                 // point on the upper row edge
      offer(KIND_SAMPLE, 0, TWO, 0, 0);                 // point on the upper column edge
      offer(KIND_SAMPLE, TWO, TWO, 0, 0);
      offer(KIND_SAMPLE, -TWO, -TWO, 0, 0);
      offer(KIND_SAMPLE, ONE, ONE, 0, 0);               // second point leaves the square
      offer(KIND_SAMPLE, -ONE, ONE / 4, 0, 0);
      offer(KIND_SAMPLE, ONE / 4, -ONE, 0, 0);
      offer(KIND_SAMPLE, -1, 1, 0, 0);
      offer(KIND_READ, TWO, -TWO, 192, 384);
      offer(KIND_READ, 0, 0, 0, 256);
      offer(KIND_READ, -TWO, TWO, 255, 511);
      offer(KIND_READ, 0, 0, 0, 0);
      offer(KIND_READ, 0, 0, 128, 255);

      // Single iteration with a zero bound: nothing can escape.
      random_phase(1, '0, 50, 30);
      // Zero limit: no iteration at all.
      random_phase(0, LIMIT_W'(TWO), 40, 30);
      // Limit above the store size with the widest bound.
      random_phase(1023, {LIMIT_W{1'b1}}, 50, 40);

      // Long receiver hold while requests keep coming.
      drain();
      write_register(CSR_MAX_ITER, LIMIT_W'(40));
      write_register(CSR_ESC_LIMIT, LIMIT_W'(4 * ONE));
      hold_request = 1;
      repeat (10) offer(KIND_READ, 0, 0, 192, 384);
      repeat (150) random_request(75);

      random_phase(3, LIMIT_W'(TWO), 100, 75);
      random_phase(512, LIMIT_W'(TWO), 130, 75);
      offer(KIND_READ, 0, 0, 192, 384);

      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("buddhabrot_orbit_histogram_core: match");
      else
         $display("buddhabrot_orbit_histogram_core: mismatch");
      $finish;
   end

endmodule

// File: buddhabrot_orbit_histogram_core.f
rtl/boh_pkg.sv
rtl/boh_ram.sv
rtl/boh_front.sv
rtl/boh_back.sv
rtl/buddhabrot_orbit_histogram_core.sv
tb/tb_buddhabrot_orbit_histogram_core.sv
